FILE: rtl/owpwm_pkg.sv
// Shared types and constants for the omni wheel speed to PWM unit.
package owpwm_pkg;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned NUM_WHEELS = 3;

    // sqrt(3) in Q16, rounded to nearest; 18 bits so it stays positive when signed.
    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    // floor(v / 3) = (v * RECIP3) >> RECIP3_SH, exact for 16-bit v.
    localparam logic [15:0] RECIP3    = 16'd43691;
    localparam int unsigned RECIP3_SH = 17;

    // floor(p / 255) = (p * RECIP255) >> RECIP255_SH, exact for 16-bit p.
    localparam logic [15:0] RECIP255    = 16'd32897;
    localparam int unsigned RECIP255_SH = 23;

    localparam logic [7:0] DUTY_SCALE  = 8'd242;
    localparam logic [8:0] DUTY_OFFSET = 9'd13;
    localparam logic [9:0] DUTY_MAX    = 10'd255;
    localparam logic [7:0] STOP_DUTY   = 8'd39;
    localparam logic [7:0] MIN_RUN_DUTY = 8'd39;

    // Any speed at or above this already gives full duty.
    localparam logic [14:0] SPEED_CLAMP = 15'd127;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        REG_ROT_GAIN_ONE   = 2'd0,
        REG_ROT_GAIN_TWO   = 2'd1,
        REG_ROT_GAIN_THREE = 2'd2
    } t_reg_idx;

endpackage

FILE: rtl/owpwm_cmd_if.sv
// Body velocity command channel.
interface owpwm_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [owpwm_pkg::SPEED_W-1:0]       speed_x;
    logic signed [owpwm_pkg::SPEED_W-1:0]       speed_y;
    logic signed [owpwm_pkg::SPEED_W-1:0]       speed_turn;

    modport source (output valid, output speed_x, output speed_y, output speed_turn,
                    input ready);
    modport sink   (input valid, input speed_x, input speed_y, input speed_turn,
                    output ready);
endinterface

FILE: rtl/owpwm_pwm_if.sv
// Wheel duty and direction result channel.
interface owpwm_pwm_if;
    logic                               valid;
    logic                               ready;
    logic [owpwm_pkg::DUTY_W-1:0]       duty_one;
    logic [owpwm_pkg::DIR_W-1:0]        dir_one;
    logic [owpwm_pkg::DUTY_W-1:0]       duty_two;
    logic [owpwm_pkg::DIR_W-1:0]        dir_two;
    logic [owpwm_pkg::DUTY_W-1:0]       duty_three;
    logic [owpwm_pkg::DIR_W-1:0]        dir_three;

    modport source (output valid, output duty_one, output dir_one, output duty_two,
                    output dir_two, output duty_three, output dir_three, input ready);
    modport sink   (input valid, input duty_one, input dir_one, input duty_two,
                    input dir_two, input duty_three, input dir_three, output ready);
endinterface

FILE: rtl/omni_wheel_speed_to_pwm_unit.sv
// Three-wheel omni drive inverse kinematics with PWM duty mapping, top level.
//
//  Channel   Direction  Handshake       Payload
//  i_cmd     in         valid/ready     speed_x, speed_y, speed_turn (Q12.4)
//  o_pwm     out        valid/ready     duty/dir for wheels one, two, three
//  i_cfg_*   in         write enable    rot_gain_one..three (Q4.12), by index
//
// Seven register stages: products, wheel sums, magnitude, divide by three,
// duty scale, divide by 255, saturate into the output register.
// One command per cycle while the output is not stalled.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output holds its transaction and bubbles behind it still close up.
// Reset empties the pipeline and loads all rotation gains with 1.0.
module omni_wheel_speed_to_pwm_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    owpwm_cmd_if.sink                           i_cmd,
    owpwm_pwm_if.source                         o_pwm,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [owpwm_pkg::GAIN_W-1:0]        i_cfg_data
);
    import owpwm_pkg::*;

    localparam int unsigned NS = 7;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    logic signed [GAIN_W-1:0] r_gain [NUM_WHEELS];

    // Stage 0: products.
    logic signed [SPEED_W-1:0] r_x;
    logic signed [33:0]        r_yt;
    logic signed [31:0]        r_pr  [NUM_WHEELS];
    logic signed [33:0]        n_yt;
    logic signed [31:0]        n_pr  [NUM_WHEELS];
    // Stage 1: wheel sums in units of 1/(3*16*65536).
    logic signed [35:0]        r_n   [NUM_WHEELS];
    logic signed [35:0]        n_n   [NUM_WHEELS];
    // Stage 2: magnitude over 2^20 and sign.
    logic [15:0]               r_v   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     r_neg2;
    logic [15:0]               n_v   [NUM_WHEELS];
    // Stage 3: truncated speed, clamped.
    logic [6:0]                r_m   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     r_nz3;
    logic [NUM_WHEELS-1:0]     r_neg3;
    logic [6:0]                n_m   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     n_nz3;
    // Stage 4: speed times 242.
    logic [14:0]               r_p   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     r_nz4;
    logic [NUM_WHEELS-1:0]     r_neg4;
    // Stage 5: floor(242 m / 255).
    logic [6:0]                r_q   [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]     r_nz5;
    logic [NUM_WHEELS-1:0]     r_neg5;
    logic [6:0]                n_q   [NUM_WHEELS];
    // Stage 6: output register.
    logic [DUTY_W-1:0]         r_duty [NUM_WHEELS];
    logic [DIR_W-1:0]          r_dir  [NUM_WHEELS];
    logic [DUTY_W-1:0]         n_duty [NUM_WHEELS];
    logic [DIR_W-1:0]          n_dir  [NUM_WHEELS];

    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || o_pwm.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_cmd.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_cmd.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_gain[k] <= GAIN_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROT_GAIN_ONE:   r_gain[0] <= i_cfg_data;
                REG_ROT_GAIN_TWO:   r_gain[1] <= i_cfg_data;
                REG_ROT_GAIN_THREE: r_gain[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0.
    always_comb begin
        n_yt = 34'(i_cmd.speed_y) * 34'(SQRT3_Q16);
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_pr[k] = 32'(r_gain[k]) * 32'(i_cmd.speed_turn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_x  <= i_cmd.speed_x;
            r_yt <= n_yt;
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_pr[k] <= n_pr[k];
            end
        end
    end

    // Stage 1.
    always_comb begin
        logic signed [35:0] xt;
        logic signed [35:0] yt;
        xt = 36'(r_x) <<< 16;
        yt = 36'(r_yt);
        n_n[0] = yt - xt + (36'(r_pr[0]) <<< 4);
        n_n[1] = (36'(r_pr[1]) <<< 4) - xt - yt;
        n_n[2] = (xt <<< 1) + (36'(r_pr[2]) <<< 4);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_n[k] <= n_n[k];
            end
        end
    end

    // Stage 2.
    always_comb begin
        logic [35:0] mag;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            mag    = r_n[k][35] ? 36'(-r_n[k]) : 36'(r_n[k]);
            n_v[k] = mag[35:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_v[k]    <= n_v[k];
                r_neg2[k] <= r_n[k][35];
            end
        end
    end

    // Stage 3: divide by three through the reciprocal.
    always_comb begin
        logic [31:0] prod;
        logic [14:0] m;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            prod     = 32'(r_v[k]) * 32'(RECIP3);
            m        = 15'(prod >> RECIP3_SH);
            n_nz3[k] = |m;
            n_m[k]   = (m > SPEED_CLAMP) ? SPEED_CLAMP[6:0] : m[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_m[k] <= n_m[k];
            end
            r_nz3  <= n_nz3;
            r_neg3 <= r_neg2;
        end
    end

    // Stage 4.
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_p[k] <= 15'(r_m[k] * DUTY_SCALE);
            end
            r_nz4  <= r_nz3;
            r_neg4 <= r_neg3;
        end
    end

    // Stage 5: divide by 255 through the reciprocal.
    always_comb begin
        logic [31:0] prod;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            prod   = 32'(r_p[k]) * 32'(RECIP255);
            n_q[k] = 7'(prod >> RECIP255_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_q[k] <= n_q[k];
            end
            r_nz5  <= r_nz4;
            r_neg5 <= r_neg4;
        end
    end

    // Stage 6: offset, times three, saturate.
    always_comb begin
        logic [8:0] s;
        logic [9:0] d;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            s = 9'(r_q[k]) + DUTY_OFFSET;
            d = (10'(s) << 1) + 10'(s);
            n_duty[k] = (d > DUTY_MAX) ? DUTY_MAX[7:0] : d[7:0];
            if (!r_nz5[k]) begin
                n_dir[k] = DIR_STOP;
            end else if (r_neg5[k]) begin
                n_dir[k] = DIR_REV;
            end else begin
                n_dir[k] = DIR_FWD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_duty[k] <= n_duty[k];
                r_dir[k]  <= n_dir[k];
            end
        end
    end

    assign o_pwm.valid      = r_vld[NS-1];
    assign o_pwm.duty_one   = r_duty[0];
    assign o_pwm.dir_one    = r_dir[0];
    assign o_pwm.duty_two   = r_duty[1];
    assign o_pwm.dir_two    = r_dir[1];
    assign o_pwm.duty_three = r_duty[2];
    assign o_pwm.dir_three  = r_dir[2];

    // A stopped wheel one always carries the idle duty.
    a_stop_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pwm.valid && o_pwm.dir_one == DIR_STOP |-> o_pwm.duty_one == STOP_DUTY)
        else $error("wheel one stopped with a duty other than the idle duty");

    // A turning wheel two has at least the duty of speed one.
    a_run_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pwm.valid && o_pwm.dir_two != DIR_STOP |-> o_pwm.duty_two >= MIN_RUN_DUTY)
        else $error("wheel two turning with a duty below the minimum");

    // An accepted transaction lands in the first stage.
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_vld[0])
        else $error("accepted command did not enter the pipeline");

endmodule
